/* rtl/core/amsg_pkg.sv */
`timescale 1ns / 1ps
package amsg_pkg;

	// field widths
	localparam int IDX_W     = 10;
	localparam int DATA_W    = 16;
	localparam int SEC_W     = 32;
	localparam int CFG_IDX_W = 3;

	// default parameter values
	localparam int NUM_WEIGHTS_DEF = 1024;
	localparam int GRAD_WIDTH_DEF  = 16;

	// register reset values
	localparam logic [15:0] ETA_RST   = 16'd655;
	localparam logic [15:0] BETA1_RST = 16'd58982;
	localparam logic [15:0] BETA2_RST = 16'd65470;
	localparam logic [15:0] EPS_RST   = 16'd1;

	// square root pipeline: 16 steps, two per stage
	localparam int SQRT_STEPS     = 16;
	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

	// divider pipeline: 32 quotient bits, two per stage
	localparam int DIV_STEPS     = 32;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
	localparam int NUM_W         = 32;
	localparam int DEN_W         = 21;
	localparam int REM_W         = 22;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARNING_RATE = 3'd0,
		REG_FIRST_DECAY   = 3'd1,
		REG_SECOND_DECAY  = 3'd2,
		REG_DENOM_FLOOR   = 3'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] eta;
		logic [15:0] beta1;
		logic [15:0] beta2;
		logic [15:0] eps;
	} cfg_t;

	// per-weight optimiser state
	typedef struct packed {
		logic signed [DATA_W-1:0] m;
		logic [SEC_W-1:0]         v;
		logic [SEC_W-1:0]         vh;
	} state_t;

	// what travels beside the root and quotient pipelines
	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic                     ok;
		logic signed [DATA_W-1:0] m;
	} side_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] nq;
	} dv_t;

	// one digit of the bitwise integer square root
	function automatic sq_t sqrt_step(sq_t a, logic [31:0] b);
		sq_t r;
		logic [31:0] t;
		t = a.root + b;
		r = a;
		if (a.x >= t) begin
			r.x    = a.x - t;
			r.root = (a.root >> 1) + b;
		end else begin
			r.root = a.root >> 1;
		end
		return r;
	endfunction

	// one restoring division step, quotient shifts in at the bottom
	function automatic dv_t div_step(dv_t a, logic [DEN_W-1:0] d);
		dv_t r;
		logic [REM_W-1:0] t;
		t    = {a.rem[REM_W-2:0], a.nq[NUM_W-1]};
		r.nq = {a.nq[NUM_W-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem   = t - {1'b0, d};
			r.nq[0] = 1'b1;
		end else begin
			r.rem = t;
		end
		return r;
	endfunction

endpackage

/* rtl/core/amsg_state.sv */
`timescale 1ns / 1ps
module amsg_state #(
	parameter int NUM_WEIGHTS = amsg_pkg::NUM_WEIGHTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_acc,
	input  logic [amsg_pkg::IDX_W-1:0]          in_idx,
	input  logic signed [amsg_pkg::DATA_W-1:0]  in_grad,
	input  amsg_pkg::cfg_t                      cfg,
	output logic                                clearing,
	output logic                                res_valid,
	output amsg_pkg::side_t                     res_side,
	output logic [amsg_pkg::SEC_W-1:0]          res_vh
);

	localparam int ADDR_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
	localparam int CNT_W  = ADDR_W + 1;

	amsg_pkg::state_t mem [NUM_WEIGHTS];
	amsg_pkg::state_t rd_q;

	logic             clr_q;
	logic [CNT_W-1:0] cnt_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [amsg_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic ok_s1, ok_s2, ok_s3;
	logic signed [amsg_pkg::DATA_W-1:0] g_s1;
	logic hit_s1;
	amsg_pkg::state_t byp_s1, st_s2, st_s3;
	logic signed [33:0] cm_s2, cm_s3;
	logic [31:0] gg_s2;
	logic [48:0] cv_s3;
	amsg_pkg::side_t side_s4;
	logic [amsg_pkg::SEC_W-1:0] vh_s4;

	logic in_ok;
	logic [ADDR_W-1:0] in_addr, wa;
	logic wr;
	amsg_pkg::state_t nxt, eff1;

	// stage 1 terms
	logic [16:0] omb1, omb2;
	logic signed [17:0] omb1_sg;
	logic signed [33:0] cm1;
	logic signed [31:0] sq1;

	// stage 2 terms
	logic [48:0] cv2;

	// stage 3 recurrence terms
	logic signed [17:0] b1_sg;
	logic signed [33:0] pm;
	logic signed [35:0] sum_m;
	logic signed [19:0] m_sh;
	logic signed [15:0] m_new;
	logic [48:0] pv;
	logic [49:0] sum_v;
	logic [33:0] v_sh;
	logic [31:0] v_new;

	assign in_ok   = 32'(in_idx) < NUM_WEIGHTS;
	assign in_addr = ADDR_W'(in_idx);
	assign wa      = ADDR_W'(idx_s3);
	assign wr      = en && v_s3 && ok_s3;
	assign clearing = clr_q;

	// clearing pass after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			cnt_q <= '0;
		end else if (clr_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_WEIGHTS - 1)) clr_q <= 1'b0;
		end
	end

	// state memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (clr_q) mem[cnt_q[ADDR_W-1:0]] <= '0;
		else if (wr) mem[wa] <= nxt;
		if (en) rd_q <= mem[in_addr];
	end

	// stage 1: gradient products
	assign omb1    = 17'h10000 - {1'b0, cfg.beta1};
	assign omb2    = 17'h10000 - {1'b0, cfg.beta2};
	assign omb1_sg = {1'b0, omb1};
	assign cm1     = omb1_sg * g_s1;
	assign sq1     = g_s1 * g_s1;
	assign eff1    = hit_s1 ? byp_s1 : rd_q;

	// stage 2: second-moment input term
	assign cv2 = 49'(omb2) * 49'(gg_s2);

	// stage 3: moment recurrence, combinational within this stage
	always_comb begin
		b1_sg = {2'b00, cfg.beta1};
		pm    = b1_sg * st_s3.m;
		sum_m = 36'(pm) + 36'(cm_s3) + 36'sd32768;
		m_sh  = 20'(sum_m >>> 16);
		if (m_sh > 20'sd32767) m_new = 16'sh7fff;
		else if (m_sh < -20'sd32768) m_new = 16'sh8000;
		else m_new = 16'(m_sh);
		pv    = 49'(cfg.beta2) * 49'(st_s3.v);
		sum_v = 50'(pv) + 50'(cv_s3) + 50'd32768;
		v_sh  = sum_v[49:16];
		v_new = (|v_sh[33:32]) ? 32'hffff_ffff : v_sh[31:0];
		nxt.m  = m_new;
		nxt.v  = v_new;
		nxt.vh = (v_new > st_s3.vh) ? v_new : st_s3.vh;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// payload, with write-back forwarded into younger beats
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= in_idx;
			ok_s1  <= in_ok;
			g_s1   <= in_grad;
			hit_s1 <= wr && (idx_s3 == in_idx);
			byp_s1 <= nxt;

			idx_s2 <= idx_s1;
			ok_s2  <= ok_s1;
			cm_s2  <= cm1;
			gg_s2  <= 32'(sq1);
			st_s2  <= (wr && idx_s3 == idx_s1) ? nxt : eff1;

			idx_s3 <= idx_s2;
			ok_s3  <= ok_s2;
			cm_s3  <= cm_s2;
			cv_s3  <= cv2;
			st_s3  <= (wr && idx_s3 == idx_s2) ? nxt : st_s2;

			side_s4.idx <= idx_s3;
			side_s4.ok  <= ok_s3;
			side_s4.m   <= nxt.m;
			vh_s4       <= nxt.vh;
		end
	end

	assign res_valid = v_s4;
	assign res_side  = side_s4;
	assign res_vh    = vh_s4;

endmodule

/* rtl/core/amsg_sqrt.sv */
`timescale 1ns / 1ps
module amsg_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [31:0]          in_x,
	input  amsg_pkg::side_t      in_side,
	output logic                 out_valid,
	output logic [15:0]          out_root,
	output amsg_pkg::side_t      out_side
);

	localparam int NS  = amsg_pkg::SQRT_STAGES;
	localparam int PER = amsg_pkg::SQRT_PER_STAGE;

	logic [NS-1:0]   v_s;
	amsg_pkg::sq_t   sq_s   [NS];
	amsg_pkg::side_t side_s [NS];

	// valid bits shift with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (en) v_s <= {v_s[NS-2:0], in_valid};
	end

	for (genvar k = 0; k < NS; k++) begin : g_st
		amsg_pkg::sq_t   cur, res;
		amsg_pkg::side_t sd;

		if (k == 0) begin : g_first
			assign cur.x    = in_x;
			assign cur.root = '0;
			assign sd       = in_side;
		end else begin : g_next
			assign cur = sq_s[k-1];
			assign sd  = side_s[k-1];
		end

		// two root digits per stage
		always_comb begin
			res = cur;
			for (int j = 0; j < PER; j++) begin
				res = amsg_pkg::sqrt_step(res, 32'h4000_0000 >> (2 * (k * PER + j)));
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k]   <= res;
				side_s[k] <= sd;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_root  = sq_s[NS-1].root[15:0];
	assign out_side  = side_s[NS-1];

endmodule

/* rtl/core/amsg_div.sv */
`timescale 1ns / 1ps
module amsg_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [amsg_pkg::NUM_W-1:0]        in_num,
	input  logic [amsg_pkg::DEN_W-1:0]        in_den,
	input  amsg_pkg::side_t                   in_side,
	output logic                              out_valid,
	output logic [amsg_pkg::NUM_W-1:0]        out_quo,
	output amsg_pkg::side_t                   out_side
);

	localparam int NS  = amsg_pkg::DIV_STAGES;
	localparam int PER = amsg_pkg::DIV_PER_STAGE;

	logic [NS-1:0]              v_s;
	amsg_pkg::dv_t              dv_s   [NS];
	logic [amsg_pkg::DEN_W-1:0] den_s  [NS];
	amsg_pkg::side_t            side_s [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (en) v_s <= {v_s[NS-2:0], in_valid};
	end

	for (genvar k = 0; k < NS; k++) begin : g_st
		amsg_pkg::dv_t              cur, res;
		logic [amsg_pkg::DEN_W-1:0] dd;
		amsg_pkg::side_t            sd;

		if (k == 0) begin : g_first
			assign cur.rem = '0;
			assign cur.nq  = in_num;
			assign dd      = in_den;
			assign sd      = in_side;
		end else begin : g_next
			assign cur = dv_s[k-1];
			assign dd  = den_s[k-1];
			assign sd  = side_s[k-1];
		end

		// two quotient bits per stage
		always_comb begin
			res = cur;
			for (int j = 0; j < PER; j++) begin
				res = amsg_pkg::div_step(res, dd);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k]   <= res;
				den_s[k]  <= dd;
				side_s[k] <= sd;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_quo   = dv_s[NS-1].nq;
	assign out_side  = side_s[NS-1];

endmodule

/* rtl/core/amsgrad_weight_update.sv */
`timescale 1ns / 1ps
// AMSGrad weight update, one gradient beat in, one delta beat out.
// Input channel: in_valid/in_ready with weight_index and grad_value (Q4.12).
// Output channel: out_valid/out_ready with weight_delta (Q4.12, saturated)
// and delta_index, in the same order as the inputs.
// Configuration: cfg_we/cfg_index/cfg_data writes eta, beta1, beta2 and
// epsilon; write only while the block is idle.
// Throughput: one beat per cycle while the skid register is empty. The moment
// update closes in one stage, with write-back forwarding for repeated indices,
// so back-to-back beats to the same weight run at full rate.
// Pipeline from input accept to out_valid: state read and update stages,
// 8 root stages, 1 set-up stage, 16 divider stages, 1 output register.
// Reset: registers go to their defaults and a clearing pass zeroes the
// state memory, one entry a cycle; in_ready stays low until it ends.
// Stall: a skid register behind the output register absorbs one beat; the
// whole pipeline, and in_ready, holds only while that skid is full.
module amsgrad_weight_update #(
	parameter int NUM_WEIGHTS = amsg_pkg::NUM_WEIGHTS_DEF,
	parameter int GRAD_WIDTH  = amsg_pkg::GRAD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [amsg_pkg::IDX_W-1:0]           weight_index,
	input  logic signed [GRAD_WIDTH-1:0]         grad_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [amsg_pkg::DATA_W-1:0]   weight_delta,
	output logic [amsg_pkg::IDX_W-1:0]           delta_index,
	input  logic                                 cfg_we,
	input  logic [amsg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                          cfg_data
);

	amsg_pkg::cfg_t cfg_q;

	logic en, acc, clearing;
	logic signed [32:0] g_wide;
	logic signed [amsg_pkg::DATA_W-1:0] g_sat;

	logic                       st_valid;
	amsg_pkg::side_t            st_side;
	logic [amsg_pkg::SEC_W-1:0] st_vh;

	logic            sq_valid;
	logic [15:0]     sq_root;
	amsg_pkg::side_t sq_side;

	logic [16:0] d_raw, d_fix;
	logic signed [16:0] m_ext;
	logic [15:0] m_abs;
	logic [31:0] num_w;

	logic                       v_s1;
	logic [amsg_pkg::NUM_W-1:0] num_s1;
	logic [amsg_pkg::DEN_W-1:0] den_s1;
	amsg_pkg::side_t            side_s1;

	logic                       dv_valid;
	logic [amsg_pkg::NUM_W-1:0] dv_quo;
	amsg_pkg::side_t            dv_side;

	logic signed [15:0] delta_w;

	logic                       ov_q, skf_q;
	logic signed [15:0]         delta_q, sk_delta_q;
	logic [amsg_pkg::IDX_W-1:0] idx_q, sk_idx_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eta   <= amsg_pkg::ETA_RST;
			cfg_q.beta1 <= amsg_pkg::BETA1_RST;
			cfg_q.beta2 <= amsg_pkg::BETA2_RST;
			cfg_q.eps   <= amsg_pkg::EPS_RST;
		end else if (cfg_we) begin
			case (amsg_pkg::reg_idx_t'(cfg_index))
				amsg_pkg::REG_LEARNING_RATE: cfg_q.eta   <= cfg_data;
				amsg_pkg::REG_FIRST_DECAY:   cfg_q.beta1 <= cfg_data;
				amsg_pkg::REG_SECOND_DECAY:  cfg_q.beta2 <= cfg_data;
				amsg_pkg::REG_DENOM_FLOOR:   cfg_q.eps   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves unless the skid register is occupied
	assign en       = !skf_q;
	assign in_ready = en && !clearing;
	assign acc      = in_valid && in_ready;

	// clamp the gradient to Q4.12
	assign g_wide = 33'(grad_value);
	always_comb begin
		if (g_wide > 33'sd32767) g_sat = 16'sh7fff;
		else if (g_wide < -33'sd32768) g_sat = 16'sh8000;
		else g_sat = 16'(g_wide);
	end

	amsg_state #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_acc   (acc),
		.in_idx   (weight_index),
		.in_grad  (g_sat),
		.cfg      (cfg_q),
		.clearing (clearing),
		.res_valid(st_valid),
		.res_side (st_side),
		.res_vh   (st_vh)
	);

	amsg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (st_valid),
		.in_x     (st_vh),
		.in_side  (st_side),
		.out_valid(sq_valid),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// divider set-up: rounding bias folded into the numerator
	always_comb begin
		d_raw = {1'b0, sq_root} + {1'b0, cfg_q.eps};
		d_fix = (d_raw == '0) ? 17'd1 : d_raw;
		m_ext = 17'(sq_side.m);
		m_abs = m_ext[16] ? 16'(-m_ext) : 16'(m_ext);
		num_w = 32'(cfg_q.eta) * 32'(m_abs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= sq_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= num_w + {12'd0, d_fix, 3'd0};
			den_s1  <= {d_fix, 4'd0};
			side_s1 <= sq_side;
		end
	end

	amsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_num   (num_s1),
		.in_den   (den_s1),
		.in_side  (side_s1),
		.out_valid(dv_valid),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// sign and saturation; an out-of-range index gives a zero delta
	always_comb begin
		if (!dv_side.ok) delta_w = '0;
		else if (dv_side.m > 16'sd0)
			delta_w = (dv_quo > 32'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, dv_quo[15:0]}));
		else
			delta_w = (dv_quo > 32'd32767) ? 16'sh7fff : 16'(dv_quo);
	end

	// output register with one-beat skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			skf_q <= 1'b0;
		end else if (!ov_q || out_ready) begin
			if (skf_q) begin
				ov_q  <= 1'b1;
				skf_q <= 1'b0;
			end else begin
				ov_q <= dv_valid;
			end
		end else if (dv_valid && en) begin
			skf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || out_ready) begin
			if (skf_q) begin
				delta_q <= sk_delta_q;
				idx_q   <= sk_idx_q;
			end else begin
				delta_q <= delta_w;
				idx_q   <= dv_side.idx;
			end
		end else if (dv_valid && en) begin
			sk_delta_q <= delta_w;
			sk_idx_q   <= dv_side.idx;
		end
	end

	assign out_valid    = ov_q;
	assign weight_delta = delta_q;
	assign delta_index  = idx_q;

	// skid only ever fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skf_q |-> ov_q) else $error("skid full with empty output register");

	// no beat enters while the state memory is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready) else $error("input ready during clearing pass");

	// an index beyond the table yields a zero delta
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (32'(delta_index) >= NUM_WEIGHTS)) |-> (weight_delta == '0))
		else $error("non-zero delta for out-of-range index");

endmodule

/* verif/amsgrad_weight_update_checker.sv */
`timescale 1ns / 1ps
module amsgrad_weight_update_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [amsg_pkg::IDX_W-1:0]         weight_index,
	input  logic signed [15:0]                 grad_value,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [amsg_pkg::DATA_W-1:0] weight_delta,
	input  logic [amsg_pkg::IDX_W-1:0]         delta_index,
	input  logic                               cfg_we,
	input  logic [amsg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data,
	output int                                 mismatches,
	output int                                 pending
);

	typedef struct {
		logic signed [15:0] delta;
		logic [9:0]         idx;
	} delta_beat_t;

	localparam int N_W = 1024;

	logic [15:0] eta, beta1, beta2, eps;
	logic signed [15:0] m_mem [N_W];
	logic [31:0] v_mem [N_W];
	logic [31:0] vh_mem [N_W];
	delta_beat_t delta_q [$];

	assign pending = delta_q.size();

	function automatic logic [31:0] int_root(logic [31:0] x);
		logic [31:0] root, bitv;
		root = 0;
		bitv = 32'h4000_0000;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x    = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// moment update and delta for one gradient beat
	function automatic delta_beat_t step_weight(logic [9:0] idx, logic signed [15:0] g);
		delta_beat_t r;
		longint m, s, sv, gl, d, num, mag;
		r.idx = idx;
		gl = g;
		m = m_mem[idx];
		s = longint'(beta1) * m + (65536 - longint'(beta1)) * gl;
		s = ((s + 32768 + (64'sd1 <<< 32)) >>> 16) - 65536;
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		m = s;
		sv = longint'(beta2) * longint'(v_mem[idx]) + (65536 - longint'(beta2)) * (gl * gl);
		sv = (sv + 32768) >>> 16;
		if (sv > 64'hFFFF_FFFF) sv = 64'hFFFF_FFFF;
		m_mem[idx] = m[15:0];
		v_mem[idx] = sv[31:0];
		if (sv[31:0] > vh_mem[idx]) vh_mem[idx] = sv[31:0];
		d = longint'(int_root(vh_mem[idx])) + longint'(eps);
		if (d == 0) d = 1;
		num = longint'(eta) * (m < 0 ? -m : m);
		mag = (2 * num + 16 * d) / (32 * d);
		if (m > 0) r.delta = (mag > 32768) ? 16'sh8000 : 16'(-mag);
		else r.delta = (mag > 32767) ? 16'sd32767 : 16'(mag);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		delta_beat_t want;
		if (!arst_n) begin
			eta   <= amsg_pkg::ETA_RST;
			beta1 <= amsg_pkg::BETA1_RST;
			beta2 <= amsg_pkg::BETA2_RST;
			eps   <= amsg_pkg::EPS_RST;
			for (int i = 0; i < N_W; i++) begin
				m_mem[i] = 0; v_mem[i] = 0; vh_mem[i] = 0;
			end
			delta_q.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
				amsg_pkg::REG_LEARNING_RATE: eta   <= cfg_data;
				amsg_pkg::REG_FIRST_DECAY:   beta1 <= cfg_data;
				amsg_pkg::REG_SECOND_DECAY:  beta2 <= cfg_data;
				amsg_pkg::REG_DENOM_FLOOR:   eps   <= cfg_data;
				default: ;
				endcase
			end
			// input beat
			if (in_valid && in_ready)
				delta_q.push_back(step_weight(weight_index, grad_value));
			// output beat
			if (out_valid && out_ready) begin
				if (delta_q.size() == 0) begin
					report_mismatch("unexpected delta beat, index", delta_index, -1);
				end else begin
					want = delta_q.pop_front();
					if (delta_index !== want.idx)
						report_mismatch("delta_index", delta_index, want.idx);
					if (weight_delta !== want.delta)
						report_mismatch("weight_delta", weight_delta, want.delta);
				end
			end
		end
	end
endmodule

/* verif/amsgrad_weight_update_tb.sv */
`timescale 1ns / 1ps
module amsgrad_weight_update_tb;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic [9:0] weight_index = 0;
	logic signed [15:0] grad_value = 0;
	logic out_valid, out_ready = 0;
	logic signed [15:0] weight_delta;
	logic [9:0] delta_index;
	logic cfg_we = 0;
	logic [amsg_pkg::CFG_IDX_W-1:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;
	int mismatches, pending;

	always #5 clk = ~clk;

	amsgrad_weight_update dut (.*);

	amsgrad_weight_update_checker chk (.*);

	// sink: random stall per beat, with stall-free stretches
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// valid stays up into the next beat when there is no gap
	task automatic send_grad(input logic [9:0] idx, input logic signed [15:0] g, input bit busy);
		int gap;
		gap = busy ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		weight_index <= idx;
		grad_value   <= g;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input amsg_pkg::reg_idx_t r, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// wait for all deltas back, then for the pipeline to empty
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic random_phase(input int n, input int nidx);
		bit busy;
		int r;
		logic signed [15:0] g;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) busy = $urandom_range(0, 1);
			r = $urandom_range(0, 9);
			g = (r < 7) ? 16'($signed($urandom_range(0, 4095)) - 2048) : 16'($urandom);
			send_grad(10'($urandom_range(0, nidx - 1)), g, busy);
			if (i == n / 2) drain();
		end
	endtask

	initial begin
		logic [15:0] extremes [6] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h1000};
		repeat (9) @(negedge clk);
		arst_n = 1;
		// directed: field extremes, repeats, bad register index, zero epsilon
		foreach (extremes[i]) send_grad(10'd0, extremes[i], 0);
		send_grad(10'd1023, 16'sh7FFF, 1);
		send_grad(10'd1023, 16'sh7FFF, 1);
		send_grad(10'd1023, -16'sh8000, 1);
		send_grad(10'd512, 16'sh0800, 0);
		send_grad(10'd512, -16'sh0800, 1);
		send_grad(10'd341, 16'sh5555, 0);
		send_grad(10'd682, -16'sh5556, 0);
		drain();
		write_reg(amsg_pkg::reg_idx_t'(3'd5), 16'hFFFF);
		write_reg(amsg_pkg::REG_DENOM_FLOOR, 16'd0);
		send_grad(10'd7, 16'sh0000, 0);
		send_grad(10'd8, 16'sh0001, 0);
		drain();
		write_reg(amsg_pkg::REG_DENOM_FLOOR, amsg_pkg::EPS_RST);
		random_phase(300, 1024);
		drain();
		write_reg(amsg_pkg::REG_LEARNING_RATE, 16'hFFFF);
		write_reg(amsg_pkg::REG_FIRST_DECAY, 16'd0);
		write_reg(amsg_pkg::REG_SECOND_DECAY, 16'd0);
		write_reg(amsg_pkg::REG_DENOM_FLOOR, 16'hFFFF);
		random_phase(200, 16);
		drain();
		write_reg(amsg_pkg::REG_LEARNING_RATE, 16'd0);
		write_reg(amsg_pkg::REG_FIRST_DECAY, 16'hFFFF);
		write_reg(amsg_pkg::REG_SECOND_DECAY, 16'hFFFF);
		write_reg(amsg_pkg::REG_DENOM_FLOOR, 16'd1);
		random_phase(150, 64);
		drain();
		write_reg(amsg_pkg::REG_LEARNING_RATE, 16'($urandom));
		write_reg(amsg_pkg::REG_FIRST_DECAY, 16'($urandom));
		write_reg(amsg_pkg::REG_SECOND_DECAY, 16'($urandom));
		write_reg(amsg_pkg::REG_DENOM_FLOOR, 16'($urandom_range(1, 65535)));
		random_phase(280, 128);
		drain();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// timeout guard
	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
